FILE: rtl/fgrc_pkg.sv
// Shared constants and types of the fuzzy grid rule classifier.
package fgrc_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int COORD_W     = 16;
    localparam int FRAC_W      = 15;
    localparam int WEIGHT_W    = 16;
    localparam int CFG_W       = 4;
    localparam int MEMB_W      = 17;
    localparam int STR_W       = 31;
    localparam int PROD_W      = 48;
    localparam int SUM_W       = 50;
    localparam int LANES       = 4;

    localparam logic [COORD_W-1:0] COORD_ONE  = 16'h8000;
    localparam logic [MEMB_W-1:0]  MEMB_ONE   = 17'h08000;
    localparam logic [CFG_W-1:0]   PART_RESET = 4'd3;
    localparam int                 PART_MIN   = 2;

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_CLASSIFY = 1'b1
    } t_cmd;

    localparam logic [1:0] SIGN_NEG  = 2'd0;
    localparam logic [1:0] SIGN_ZERO = 2'd1;
    localparam logic [1:0] SIGN_POS  = 2'd2;

endpackage

FILE: rtl/fuzzy_grid_rule_classifier.sv
// Top level of the fuzzy grid rule classifier: six-stage pipeline over four weight RAM copies.
//
//  channel   ports                                             direction  handshake
//  command   start, busy, i_command, i_weight_index,
//            i_weight_value, i_x_coord, i_y_coord              in         start && !busy
//  result    o_result_valid, o_class_sign, o_inference_value   out        strobe, one cycle
//  config    i_cfg_we, i_cfg_wdata                             in         write enable
//
//  One beat per cycle in; busy is always low. A classify beat gives its result through the
//  locate, index, RAM read, multiply, sum and round stages. A load beat passes the r_s1_ld
//  and r_s2_ld registers and then writes all four weight RAM copies at the stage where
//  classify beats read them, so beats keep their order.
//  Reset sets the partition register to three and clears the pipeline valid bits and
//  the per-rule written flags; an unwritten rule reads as zero. The receiver takes every strobe.
module fuzzy_grid_rule_classifier #(
    parameter int MAX_PARTITIONS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cfg_we,
    input  logic [fgrc_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic                                    i_command,
    input  logic [fgrc_pkg::ADDR_W-1:0]             i_weight_index,
    input  logic signed [fgrc_pkg::WEIGHT_W-1:0]    i_weight_value,
    input  logic [fgrc_pkg::COORD_W-1:0]            i_x_coord,
    input  logic [fgrc_pkg::COORD_W-1:0]            i_y_coord,
    output logic                                    o_result_valid,
    output logic [1:0]                              o_class_sign,
    output logic signed [fgrc_pkg::WEIGHT_W-1:0]    o_inference_value
);

    localparam int PW  = $clog2(MAX_PARTITIONS + 1);
    localparam int KW  = $clog2(MAX_PARTITIONS);
    localparam int TW  = fgrc_pkg::COORD_W + KW;
    localparam int IW  = (2 * PW + 1 > fgrc_pkg::ADDR_W + 1) ? 2 * PW + 1
                                                              : fgrc_pkg::ADDR_W + 1;
    localparam int AW  = fgrc_pkg::ADDR_W;
    localparam int WW  = fgrc_pkg::WEIGHT_W;
    localparam int MW  = fgrc_pkg::MEMB_W;
    localparam int FW  = fgrc_pkg::FRAC_W;
    localparam int NL  = fgrc_pkg::LANES;

    logic accept;
    logic load_we;

    logic [fgrc_pkg::CFG_W-1:0]       r_partitions;
    logic [fgrc_pkg::STORE_DEPTH-1:0] r_wvalid;

    logic                       r_s1_ld;
    logic [AW-1:0]              r_s1_widx;
    logic [WW-1:0]              r_s1_wval;
    logic                       r_s2_ld;
    logic [AW-1:0]              r_s2_widx;
    logic [WW-1:0]              r_s2_wval;

    logic [PW-1:0]              n_p;
    logic [KW-1:0]              n_pm1;
    logic [fgrc_pkg::COORD_W-1:0] n_coord [2];
    logic [fgrc_pkg::COORD_W-1:0] n_csat  [2];
    logic [TW-1:0]              n_t     [2];
    logic [KW-1:0]              n_cell  [2];
    logic [FW-1:0]              n_frac  [2];

    logic                       r_s1_vld;
    logic [PW-1:0]              r_s1_p;
    logic [KW-1:0]              r_s1_cell [2];
    logic [FW-1:0]              r_s1_frac [2];

    logic [IW-1:0]              n_idx   [NL];
    logic [PW-1:0]              n_xi    [NL];
    logic [PW-1:0]              n_yi    [NL];
    logic                       r_s2_vld;
    logic [AW-1:0]              r_s2_addr [NL];
    logic                       r_s2_inr  [NL];
    logic [MW-1:0]              r_s2_mx   [2];
    logic [MW-1:0]              r_s2_my   [2];

    logic [2*MW-1:0]            n_str   [NL];
    logic [WW-1:0]              w_rdata [NL];
    logic                       r_s3_vld;
    logic                       r_s3_wok  [NL];
    logic [fgrc_pkg::STR_W-1:0] r_s3_str  [NL];

    logic signed [WW-1:0]       n_weff  [NL];
    logic signed [fgrc_pkg::PROD_W-1:0] n_prod [NL];
    logic                       r_s4_vld;
    logic signed [fgrc_pkg::PROD_W-1:0] r_s4_prod [NL];

    logic signed [fgrc_pkg::SUM_W-1:0]  n_sum;
    logic                       r_s5_vld;
    logic signed [fgrc_pkg::SUM_W-1:0]  r_s5_sum;

    logic signed [fgrc_pkg::SUM_W-31:0] n_fl;
    logic signed [WW-1:0]       n_value;
    logic [1:0]                 n_sign;
    logic                       r_out_vld;
    logic [1:0]                 r_out_sign;
    logic signed [WW-1:0]       r_out_value;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign load_we = accept && (i_command == fgrc_pkg::CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partitions <= fgrc_pkg::PART_RESET;
        end else if (i_cfg_we) begin
            r_partitions <= i_cfg_wdata;
        end
    end

    // delay loads to the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ld <= 1'b0;
            r_s2_ld <= 1'b0;
        end else begin
            r_s1_ld <= load_we;
            r_s2_ld <= r_s1_ld;
        end
        r_s1_widx <= i_weight_index;
        r_s1_wval <= i_weight_value;
        r_s2_widx <= r_s1_widx;
        r_s2_wval <= r_s1_wval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (r_s2_ld) begin
            r_wvalid[r_s2_widx] <= 1'b1;
        end
    end

    // locate: cell and fraction per axis
    always_comb begin
        priority if (int'(r_partitions) < fgrc_pkg::PART_MIN) begin
            n_p = PW'(fgrc_pkg::PART_MIN);
        end else if (int'(r_partitions) > MAX_PARTITIONS) begin
            n_p = PW'(MAX_PARTITIONS);
        end else begin
            n_p = PW'(r_partitions);
        end
        n_pm1      = KW'(n_p - PW'(1));
        n_coord[0] = i_x_coord;
        n_coord[1] = i_y_coord;
        for (int j = 0; j < 2; j++) begin
            n_csat[j] = (n_coord[j] > fgrc_pkg::COORD_ONE) ? fgrc_pkg::COORD_ONE
                                                            : n_coord[j];
            n_t[j]    = TW'(n_csat[j]) * TW'(n_pm1);
            if (n_t[j][TW-1:FW] >= (KW+1)'(n_pm1)) begin
                n_cell[j] = n_pm1;
                n_frac[j] = '0;
            end else begin
                n_cell[j] = n_t[j][FW+KW-1:FW];
                n_frac[j] = n_t[j][FW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept && (i_command == fgrc_pkg::CMD_CLASSIFY);
        end
        r_s1_p <= n_p;
        for (int j = 0; j < 2; j++) begin
            r_s1_cell[j] <= n_cell[j];
            r_s1_frac[j] <= n_frac[j];
        end
    end

    // rule indices of the four neighbours, lane = 2*ystep + xstep
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_xi[k]  = PW'(r_s1_cell[0]) + PW'(k % 2);
            n_yi[k]  = PW'(r_s1_cell[1]) + PW'(k / 2);
            n_idx[k] = IW'(n_yi[k]) * IW'(r_s1_p) + IW'(n_xi[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        for (int k = 0; k < NL; k++) begin
            r_s2_addr[k] <= n_idx[k][AW-1:0];
            r_s2_inr[k]  <= n_idx[k] < IW'(fgrc_pkg::STORE_DEPTH);
        end
        for (int j = 0; j < 2; j++) begin
            r_s2_mx[j] <= (j == 0) ? fgrc_pkg::MEMB_ONE - MW'(r_s1_frac[0])
                                   : MW'(r_s1_frac[0]);
            r_s2_my[j] <= (j == 0) ? fgrc_pkg::MEMB_ONE - MW'(r_s1_frac[1])
                                   : MW'(r_s1_frac[1]);
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_wram
        fgrc_ram #(
            .WIDTH (WW),
            .DEPTH (fgrc_pkg::STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_s2_ld),
            .i_waddr (r_s2_widx),
            .i_wdata (r_s2_wval),
            .i_raddr (r_s2_addr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_str[k] = r_s2_mx[k % 2] * r_s2_my[k / 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        for (int k = 0; k < NL; k++) begin
            r_s3_wok[k] <= r_wvalid[r_s2_addr[k]] && r_s2_inr[k];
            r_s3_str[k] <= n_str[k][fgrc_pkg::STR_W-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_weff[k] = r_s3_wok[k] ? $signed(w_rdata[k]) : '0;
            n_prod[k] = $signed({1'b0, r_s3_str[k]}) * n_weff[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        for (int k = 0; k < NL; k++) begin
            r_s4_prod[k] <= n_prod[k];
        end
    end

    assign n_sum = fgrc_pkg::SUM_W'(r_s4_prod[0]) + fgrc_pkg::SUM_W'(r_s4_prod[1])
                 + fgrc_pkg::SUM_W'(r_s4_prod[2]) + fgrc_pkg::SUM_W'(r_s4_prod[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
        r_s5_sum <= n_sum;
    end

    // floor to Q3.12, saturate, classify sign
    always_comb begin
        n_fl = r_s5_sum[fgrc_pkg::SUM_W-1:30];
        priority if (n_fl > 32767) begin
            n_value = 16'sh7FFF;
        end else if (n_fl < -32768) begin
            n_value = -16'sh8000;
        end else begin
            n_value = n_fl[WW-1:0];
        end
        priority if (r_s5_sum > 0) begin
            n_sign = fgrc_pkg::SIGN_POS;
        end else if (r_s5_sum < 0) begin
            n_sign = fgrc_pkg::SIGN_NEG;
        end else begin
            n_sign = fgrc_pkg::SIGN_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s5_vld;
        end
        r_out_sign  <= n_sign;
        r_out_value <= n_value;
    end

    assign o_result_valid    = r_out_vld;
    assign o_class_sign      = r_out_sign;
    assign o_inference_value = r_out_value;

`ifndef SYNTH
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            $past(accept && (i_command == fgrc_pkg::CMD_CLASSIFY), 6))
        else $error("result strobe without a classify beat six cycles earlier");

    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_class_sign == fgrc_pkg::SIGN_NEG) |-> (o_inference_value < 0))
        else $error("negative class with non-negative value");

    a_sign_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_class_sign == fgrc_pkg::SIGN_ZERO) |-> (o_inference_value == 0))
        else $error("zero class with non-zero value");

    a_load_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_ld |=> r_wvalid[$past(r_s2_widx)])
        else $error("loaded rule not marked as written");
`endif

endmodule

FILE: rtl/fgrc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fgrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
